// File: design/rdq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rdq_pkg
// Shared types and codes for the reversible double-ended queue.
// ---------------------------------------------------------------------------
package rdq_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int OCC_W    = 11;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_POP_BACK   = 3'd0;
  localparam cmd_t CMD_POP_FRONT  = 3'd1;
  localparam cmd_t CMD_REVERSE    = 3'd2;
  localparam cmd_t CMD_PUSH_BACK  = 3'd3;
  localparam cmd_t CMD_PUSH_FRONT = 3'd4;

  localparam status_t ST_POPPED  = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_DONE    = 2'd2;
  localparam status_t ST_DROPPED = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage : rdq_pkg
`default_nettype wire

// File: design/reversible_deque_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// reversible_deque_unit
// Double-ended queue of signed 32-bit words with constant-time reverse,
// held in a ring memory with head and tail pointers and a direction flag.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Ports
//  -------  ---------  -----------------------------------------------------
//  in       input      in_valid, in_ready, in_cmd, in_push_value
//  out      output     out_valid, out_ready, out_status, out_pop_value,
//                      out_occupancy
//
// A push, reverse, dropped push or pop of an empty queue registers its
// result from the command; a word pop waits in S_READ for the registered
// memory read. Pointers, count and flag are updated on command accept.
// Reset is synchronous and clears all control state; the memory is not
// cleared. A command word is taken while a result waits only if that
// result is being taken in the same cycle.
module reversible_deque_unit
  import rdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [CMD_W-1:0]           in_cmd,
  input  wire logic signed [WORD_W-1:0]   in_push_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic signed [WORD_W-1:0]        out_pop_value,
  output logic [OCC_W-1:0]                out_occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [WORD_W-1:0] pop_r, pop_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_W-1:0] rdata_r;

  logic accept, out_free, empty, full, phys_front, rev_eff;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);
  assign head_inc = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_PTR : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_PTR : tail_r - 1'b1;

  // A push into an empty queue always runs in normal direction.
  assign rev_eff    = empty ? 1'b0 : rev_r;
  assign phys_front = rev_eff ^ ((in_cmd == CMD_POP_FRONT) || (in_cmd == CMD_PUSH_FRONT));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    pop_nxt       = pop_r;
    occ_nxt       = occ_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = tail_r;
    raddr         = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          pop_nxt       = '0;
          occ_nxt       = OCC_W'(count_r);
          case (in_cmd)
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                // Result is sent once the memory read returns.
                out_valid_nxt = 1'b0;
                re            = 1'b1;
                state_nxt     = S_READ;
                count_nxt     = count_r - 1'b1;
                if (count_r == CW'(1)) begin
                  rev_nxt = 1'b0;
                end
                if (phys_front) begin
                  raddr    = head_r;
                  head_nxt = head_inc;
                end else begin
                  raddr    = tail_dec;
                  tail_nxt = tail_dec;
                end
              end
            end
            CMD_REVERSE: begin
              rev_nxt = !rev_r;
            end
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_DROPPED;
              end else begin
                we        = 1'b1;
                rev_nxt   = rev_eff;
                count_nxt = count_r + 1'b1;
                occ_nxt   = OCC_W'(count_r + 1'b1);
                if (phys_front) begin
                  waddr    = head_dec;
                  head_nxt = head_dec;
                end else begin
                  waddr    = tail_r;
                  tail_nxt = tail_inc;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_POPPED;
          pop_nxt       = rdata_r;
          occ_nxt       = OCC_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    occ_r    <= occ_nxt;
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_push_value;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_pop_value = pop_r;
  assign out_occupancy = occ_r;

endmodule : reversible_deque_unit
`default_nettype wire
